[rtl/chacha20_stream_cipher_assert.svh]
// Assertion macros used by the ChaCha20 stream cipher top level.
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CC20_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cc20 assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CC20_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cc20 assertion failed");

`endif

[rtl/cc20_pkg.sv]
// Types, constants and helper functions of the ChaCha20 stream cipher.
`timescale 1ns / 1ps

package cc20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int HALF_STEPS    = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W        = $clog2(HALF_STEPS);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                          32'h79622d32, 32'h6b206574};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0     = 3'd0,
        REG_KEY1     = 3'd1,
        REG_KEY2     = 3'd2,
        REG_KEY3     = 3'd3,
        REG_NONCE_LO = 3'd4,
        REG_NONCE_HI = 3'd5,
        REG_INIT_CTR = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [63:0] msg_chunk;
        logic [3:0]  valid_bytes;
        logic        last_chunk;
    } in_item_t;

    typedef struct packed {
        logic [63:0] cipher_chunk;
        logic [3:0]  out_valid_bytes;
        logic        out_last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } quad_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       load;
        logic       use_init_ctr;
        logic       half_step;
        logic       second_half;
        logic       diagonal;
        logic       finish;
        logic       emit;
        logic [2:0] chunk_idx;
    } cc20_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_last;
    } cc20_status_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        rotl32 = (x << n) | (x >> (32 - n));
    endfunction

    // Half of a quarter round: two add-xor-rotate steps.
    function automatic quad_t qr_half(input quad_t q, input logic second);
        quad_t r;
        int    r1;
        int    r2;
        r1 = second ? 8 : 16;
        r2 = second ? 7 : 12;
        r.a = q.a + q.b;
        r.d = rotl32(q.d ^ r.a, r1);
        r.c = q.c + r.d;
        r.b = rotl32(q.b ^ r.c, r2);
        return r;
    endfunction

    // Byte mask for a valid count; counts above eight keep all bytes.
    function automatic logic [63:0] byte_mask(input logic [3:0] vb);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = (vb > 4'(i)) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

[rtl/chacha20_stream_cipher.sv]
// Top level of the ChaCha20 stream cipher (RFC 8439, IETF variant).
`timescale 1ns / 1ps

// ChaCha20 XOR stream cipher: each item carries up to eight message bytes and
// comes back XORed with the keystream, bytes past the valid count zeroed.
// Encryption and decryption are the same. The key, nonce and initial counter
// are written through the cfg_we / cfg_index / cfg_wdata port (index 0-3 key
// parts, 4 nonce low, 5 nonce high, 6 initial counter). The user must write
// them only while the block is idle; the block itself does not enforce this.
// The block handles one item at a time. An item that starts a 64-byte
// keystream block goes through a load step, the half quarter rounds on four
// parallel quarter-round units, a feed-forward step and an output step. The
// other seven items of the block go straight to the output step. The output
// register lets a result wait for m_ready while the next item is already in
// work.

module chacha20_stream_cipher
    import cc20_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // message items in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    // cipher items out
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

`include "chacha20_stream_cipher_assert.svh"

    cc20_cmd_t    cmd;
    cc20_status_t status;

    // Sequence load, rounds, feed-forward and output; track chunk position.
    cc20_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold config, the working state, the keystream block and the item regs.
    cc20_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .cmd       (cmd),
        .status    (status),
        .m_item    (m_item)
    );

    // Only one item is in work: after an accept, ready must drop.
    `CC20_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)
    // A new result only appears from the output step, never from idle.
    `CC20_ASSERT_NOW(a_emit_not_idle, $rose(m_valid), !$past(s_ready))

endmodule

[rtl/cc20_ctrl.sv]
// Controller state machine of the ChaCha20 stream cipher.
`timescale 1ns / 1ps

module cc20_ctrl
    import cc20_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  cc20_status_t status,
    output cc20_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOAD   = 5'b00010,
        ST_ROUND  = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [2:0]        chunk_idx_reg, chunk_idx_next;
    logic              msg_start_reg, msg_start_next;
    logic              use_init_reg, use_init_next;
    logic              m_valid_reg, m_valid_next;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        chunk_idx_next = chunk_idx_reg;
        msg_start_next = msg_start_reg;
        use_init_next  = use_init_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd            = '0;
        cmd.chunk_idx  = chunk_idx_reg;
        cmd.use_init_ctr = use_init_reg;
        cmd.second_half  = step_reg[0];
        cmd.diagonal     = step_reg[1];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (msg_start_reg) begin
                        chunk_idx_next = '0;
                        msg_start_next = 1'b0;
                        use_init_next  = 1'b1;
                        state_next     = ST_LOAD;
                    end else if (chunk_idx_reg == 3'd0) begin
                        use_init_next = 1'b0;
                        state_next    = ST_LOAD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.half_step = 1'b1;
                if (step_reg == STEP_W'(HALF_STEPS - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit       = 1'b1;
                    m_valid_next   = 1'b1;
                    chunk_idx_next = chunk_idx_reg + 1'b1;
                    msg_start_next = status.in_last;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            chunk_idx_reg <= '0;
            msg_start_reg <= 1'b1;
            use_init_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            chunk_idx_reg <= chunk_idx_next;
            msg_start_reg <= msg_start_next;
            use_init_reg  <= use_init_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/cc20_dp.sv]
// Datapath of the ChaCha20 stream cipher: registers, round logic, output.
`timescale 1ns / 1ps

module cc20_dp
    import cc20_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              s_item,
    input  cc20_cmd_t             cmd,
    output cc20_status_t          status,
    output out_item_t             m_item
);

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_lo_reg;
    logic [31:0] nonce_hi_reg, init_ctr_reg;
    logic [31:0] blk_cnt_reg, cnt_used_reg;
    in_item_t    in_reg;
    out_item_t   out_reg;
    logic [31:0] w_reg  [16];
    logic [31:0] ks_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] init_w [16];
    logic [31:0] load_ctr;
    logic [3:0]  qa [4], qb [4], qc [4], qd [4];
    quad_t       qin [4], qout [4];
    logic [63:0] ks64;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            init_ctr_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY0:     key0_reg     <= cfg_wdata;
                REG_KEY1:     key1_reg     <= cfg_wdata;
                REG_KEY2:     key2_reg     <= cfg_wdata;
                REG_KEY3:     key3_reg     <= cfg_wdata;
                REG_NONCE_LO: nonce_lo_reg <= cfg_wdata;
                REG_NONCE_HI: nonce_hi_reg <= cfg_wdata[31:0];
                REG_INIT_CTR: init_ctr_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init_w[i] = SIGMA[i];
        end
        init_w[4]  = key0_reg[31:0];
        init_w[5]  = key0_reg[63:32];
        init_w[6]  = key1_reg[31:0];
        init_w[7]  = key1_reg[63:32];
        init_w[8]  = key2_reg[31:0];
        init_w[9]  = key2_reg[63:32];
        init_w[10] = key3_reg[31:0];
        init_w[11] = key3_reg[63:32];
        init_w[12] = cnt_used_reg;
        init_w[13] = nonce_lo_reg[31:0];
        init_w[14] = nonce_lo_reg[63:32];
        init_w[15] = nonce_hi_reg;
    end

    assign load_ctr = cmd.use_init_ctr ? init_ctr_reg : blk_cnt_reg;

    // Column or diagonal grouping of the four quarter rounds.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qa[i] = {2'b00, 2'(i)};
            qb[i] = {2'b01, 2'(i + (cmd.diagonal ? 1 : 0))};
            qc[i] = {2'b10, 2'(i + (cmd.diagonal ? 2 : 0))};
            qd[i] = {2'b11, 2'(i + (cmd.diagonal ? 3 : 0))};
            qin[i].a = w_reg[qa[i]];
            qin[i].b = w_reg[qb[i]];
            qin[i].c = w_reg[qc[i]];
            qin[i].d = w_reg[qd[i]];
            qout[i]  = qr_half(qin[i], cmd.second_half);
        end
        for (int j = 0; j < 16; j++) begin
            w_next[j] = w_reg[j];
        end
        for (int i = 0; i < 4; i++) begin
            w_next[qa[i]] = qout[i].a;
            w_next[qb[i]] = qout[i].b;
            w_next[qc[i]] = qout[i].c;
            w_next[qd[i]] = qout[i].d;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int j = 0; j < 16; j++) begin
                w_reg[j] <= (j == 12) ? load_ctr : init_w[j];
            end
            cnt_used_reg <= load_ctr;
        end else if (cmd.half_step) begin
            for (int j = 0; j < 16; j++) begin
                w_reg[j] <= w_next[j];
            end
        end
        if (cmd.finish) begin
            for (int j = 0; j < 16; j++) begin
                ks_reg[j] <= w_reg[j] + init_w[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_cnt_reg <= '0;
        end else if (cmd.finish) begin
            blk_cnt_reg <= cnt_used_reg + 32'd1;
        end
    end

    assign ks64 = {ks_reg[{cmd.chunk_idx, 1'b1}], ks_reg[{cmd.chunk_idx, 1'b0}]};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_item;
        end
        if (cmd.emit) begin
            out_reg.cipher_chunk    <= (in_reg.msg_chunk ^ ks64) & byte_mask(in_reg.valid_bytes);
            out_reg.out_valid_bytes <= in_reg.valid_bytes;
            out_reg.out_last        <= in_reg.last_chunk;
        end
    end

    assign status.in_last = in_reg.last_chunk;
    assign m_item         = out_reg;

endmodule

[tb/sv/cc20_cipher_checker.sv]
// Checker for the ChaCha20 stream cipher: keystream prediction and result compare.
`timescale 1ns / 1ps

module cc20_cipher_checker
    import cc20_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_item,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_item,
    output int                    mismatch_count,
    output int                    chunks_due
);

    localparam logic [31:0] EXPAND_0   = 32'h61707865;
    localparam logic [31:0] EXPAND_1   = 32'h3320646e;
    localparam logic [31:0] EXPAND_2   = 32'h79622d32;
    localparam logic [31:0] EXPAND_3   = 32'h6b206574;
    localparam int          REPORT_MAX = 10;

    // Shadow of the configuration registers and of the cipher state.
    logic [63:0]       key_q [4];
    logic [63:0]       nonce_lo_q;
    logic [31:0]       nonce_hi_q;
    logic [31:0]       ctr_init_q;
    logic [31:0]       blk_ctr;
    logic [2:0]        slot;
    logic              msg_open;
    logic [15:0][31:0] ks_words;

    out_item_t cipher_due_q [$];

    initial begin
        mismatch_count = 0;
        chunks_due     = 0;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // One quarter round on words a, b, c, d of the working block.
    function automatic logic [15:0][31:0] mix(input logic [15:0][31:0] w,
                                              input int a, input int b,
                                              input int c, input int d);
        logic [15:0][31:0] r;
        r    = w;
        r[a] = r[a] + r[b];  r[d] = rol32(r[d] ^ r[a], 16);
        r[c] = r[c] + r[d];  r[b] = rol32(r[b] ^ r[c], 12);
        r[a] = r[a] + r[b];  r[d] = rol32(r[d] ^ r[a], 8);
        r[c] = r[c] + r[d];  r[b] = rol32(r[b] ^ r[c], 7);
        return r;
    endfunction

    function automatic logic [15:0][31:0] keystream_block(input logic [31:0] ctr);
        logic [15:0][31:0] init_w;
        logic [15:0][31:0] w;
        init_w[0] = EXPAND_0;
        init_w[1] = EXPAND_1;
        init_w[2] = EXPAND_2;
        init_w[3] = EXPAND_3;
        for (int i = 0; i < 4; i++) begin
            init_w[4 + 2*i] = key_q[i][31:0];
            init_w[5 + 2*i] = key_q[i][63:32];
        end
        init_w[12] = ctr;
        init_w[13] = nonce_lo_q[31:0];
        init_w[14] = nonce_lo_q[63:32];
        init_w[15] = nonce_hi_q;
        w = init_w;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            w = mix(w, 0, 4,  8, 12);
            w = mix(w, 1, 5,  9, 13);
            w = mix(w, 2, 6, 10, 14);
            w = mix(w, 3, 7, 11, 15);
            w = mix(w, 0, 5, 10, 15);
            w = mix(w, 1, 6, 11, 12);
            w = mix(w, 2, 7,  8, 13);
            w = mix(w, 3, 4,  9, 14);
        end
        for (int i = 0; i < 16; i++) begin
            w[i] = w[i] + init_w[i];
        end
        return w;
    endfunction

    // Advance the cipher state by one chunk and return the result it must give.
    task automatic predict_cipher(input in_item_t it, output out_item_t res);
        logic [63:0] pad;
        logic [63:0] keep;
        int          nb;
        int          wi;
        if (!msg_open) begin
            blk_ctr  = ctr_init_q;
            slot     = 3'd0;
            msg_open = 1'b1;
        end
        if (slot == 3'd0) begin
            ks_words = keystream_block(blk_ctr);
            blk_ctr  = blk_ctr + 32'd1;
        end
        wi  = 2 * int'(slot);
        pad = {ks_words[wi + 1], ks_words[wi]};
        nb  = (it.valid_bytes > 4'd8) ? 8 : int'(it.valid_bytes);
        for (int i = 0; i < 8; i++) begin
            keep[i*8 +: 8] = (i < nb) ? 8'hff : 8'h00;
        end
        res.cipher_chunk    = (it.msg_chunk ^ pad) & keep;
        res.out_valid_bytes = it.valid_bytes;
        res.out_last        = it.last_chunk;
        slot = slot + 3'd1;
        if (it.last_chunk) begin
            msg_open = 1'b0;
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t due;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_q[i] = '0;
            nonce_lo_q = '0;
            nonce_hi_q = '0;
            ctr_init_q = '0;
            blk_ctr    = '0;
            slot       = '0;
            msg_open   = 1'b0;
            ks_words   = '0;
            cipher_due_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    REG_KEY0:     key_q[0]   = cfg_wdata;
                    REG_KEY1:     key_q[1]   = cfg_wdata;
                    REG_KEY2:     key_q[2]   = cfg_wdata;
                    REG_KEY3:     key_q[3]   = cfg_wdata;
                    REG_NONCE_LO: nonce_lo_q = cfg_wdata;
                    REG_NONCE_HI: nonce_hi_q = cfg_wdata[31:0];
                    REG_INIT_CTR: ctr_init_q = cfg_wdata[31:0];
                    default:      ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (cipher_due_q.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("%0t: unexpected cipher item %h/%0d/%0b, none due", $time,
                                 m_item.cipher_chunk, m_item.out_valid_bytes, m_item.out_last);
                    mismatch_count++;
                end else begin
                    due = cipher_due_q.pop_front();
                    if (m_item.cipher_chunk !== due.cipher_chunk ||
                        m_item.out_valid_bytes !== due.out_valid_bytes ||
                        m_item.out_last !== due.out_last) begin
                        if (mismatch_count < REPORT_MAX)
                            $display("%0t: cipher item mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                     $time, due.cipher_chunk, due.out_valid_bytes, due.out_last,
                                     m_item.cipher_chunk, m_item.out_valid_bytes,
                                     m_item.out_last);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_cipher(s_item, due);
                cipher_due_q.push_back(due);
            end
        end
        chunks_due = cipher_due_q.size();
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the ChaCha20 stream cipher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import cc20_pkg::*;

    // Index 7 has no register behind it; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 260;
    // Start the long receiver hold-off once this many items went in.
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    // Leave room past the last item for a fresh keystream block.
    localparam int END_WAIT    = 100;
    // Watchdog limit for a slow but correct run of ~1600 items, each with its
    // rounds plus receiver stalls and sender gaps.
    localparam int CYCLE_LIMIT = 600000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;

    int mismatch_count;
    int chunks_due;
    int items_sent  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int msg_left    = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    chacha20_stream_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    cc20_cipher_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .mismatch_count (mismatch_count),
        .chunks_due     (chunks_due)
    );

    // Watchdog: a hung block ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("chacha20_stream_cipher test failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Message or key data: mostly random, now and then all zeros or all ones.
    function automatic logic [63:0] pick_data();
        case ($urandom_range(0, 15))
            0:       return 64'h0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    // Initial counter: favor zero, all ones and values just below the wrap.
    function automatic logic [31:0] pick_counter();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            2:       return 32'hffff_ffff - 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // Sender pacing: bursts of random length, separated by random gaps.
    // Drop valid only at the start of a gap, never in a step that raises it.
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    // Offer one item and hold it until the block takes it; return at a falling edge.
    task automatic send_item(input logic [63:0] msg, input logic [3:0] vb, input logic last);
        in_item_t it;
        pace();
        it.msg_chunk   = msg;
        it.valid_bytes = vb;
        it.last_chunk  = last;
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Stop offering and wait until every result due has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (chunks_due != 0);
    endtask

    // Leave cfg_we high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    // Write every register; junk in the upper half of the 32-bit ones must be dropped.
    task automatic load_config(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3,
                               input logic [63:0] nlo, input logic [31:0] nhi,
                               input logic [31:0] ctr, input logic spare);
        write_reg(REG_KEY0,     k0);
        write_reg(REG_KEY1,     k1);
        write_reg(REG_KEY2,     k2);
        write_reg(REG_KEY3,     k3);
        write_reg(REG_NONCE_LO, nlo);
        write_reg(REG_NONCE_HI, {$urandom, nhi});
        write_reg(REG_INIT_CTR, {$urandom, ctr});
        if (spare) write_reg(REG_SPARE, 64'h0);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed messages with random content; the rest is noise
    // chunks with any byte count and a random last flag.
    task automatic send_random_item();
        if (msg_left == 0 && $urandom_range(0, 99) < 15) begin
            send_item(pick_data(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end else begin
            if (msg_left == 0)
                msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(1, 12);
            if (msg_left == 1)
                send_item(pick_data(), 4'($urandom_range(1, 8)), 1'b1);
            else
                send_item(pick_data(), 4'd8, 1'b0);
            msg_left--;
        end
    endtask

    // Receiver: switch between stall patterns at random intervals, and
    // once hold ready low for a long stretch so the block backs up.
    initial begin : receiver
        int          mode;
        int          run_left;
        int          hold_left;
        bit          hold_done;
        logic [15:0] pat;
        mode      = 0;
        run_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        pat       = '0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(8, 80);
                    pat      = 16'($urandom);
                end
                run_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= pat[run_left % 16];
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset configuration (all zero): full, empty, oversized and short chunks.
        send_item('1,          4'd8,  1'b0);
        send_item(64'h0,       4'd0,  1'b0);
        send_item(rand64(),    4'd15, 1'b0);
        send_item('1,          4'd4,  1'b1);

        // Byte-ordered key and nonce, counter one, two-chunk message.
        drain();
        load_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                    64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                    64'h4a00000009000000, 32'h0, 32'h1, 1'b0);
        send_item(rand64(), 4'd8, 1'b0);
        send_item(rand64(), 4'd5, 1'b1);

        // All ones everywhere, counter at the top: cross a block boundary so
        // the counter wraps, with a short chunk that is not last and a count
        // above eight in the middle. Poke the unused index last.
        drain();
        load_config('1, '1, '1, '1, '1, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_item(rand64(), 4'd8, 1'b0);
        send_item('1,       4'd3, 1'b0);
        send_item(rand64(), 4'd9, 1'b0);
        send_item(64'h0,    4'd1, 1'b0);
        for (int i = 0; i < 7; i++) begin
            send_item((i % 2) ? 64'h0 : '1, 4'd8, 1'b0);
        end
        send_item(rand64(), 4'd7, 1'b1);
        // Next message restarts at the initial counter.
        send_item(rand64(), 4'd8, 1'b1);

        // Random phases, each with a fresh configuration. A phase may end in
        // the middle of a message, so key and counter changes land mid-message.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            if (ph == 0)
                load_config(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0);
            else
                load_config(pick_data(), pick_data(), pick_data(), pick_data(),
                            pick_data(), pick_counter(), pick_counter(), 1'b0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_random_item();
            end
        end

        drain();
        repeat (END_WAIT) @(negedge aclk);
        if (mismatch_count == 0 && chunks_due == 0)
            $display("chacha20_stream_cipher test passed");
        else
            $display("chacha20_stream_cipher test failed");
        $finish;
    end

endmodule

[chacha20_stream_cipher.f]
+incdir+rtl
rtl/cc20_pkg.sv
rtl/cc20_ctrl.sv
rtl/cc20_dp.sv
rtl/chacha20_stream_cipher.sv
tb/sv/cc20_cipher_checker.sv
tb/sv/tb_top.sv
